>>> sv/framed_word_link_endpoint_assert.svh
// Assertion helpers shared by the link endpoint RTL.
`ifndef FRAMED_WORD_LINK_ENDPOINT_ASSERT_SVH
`define FRAMED_WORD_LINK_ENDPOINT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FWL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fwl assertion failed");

// Next-cycle implication, disabled during reset.
`define FWL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fwl assertion failed");

`endif

>>> sv/fwl_pkg.sv
`default_nettype none

package fwl_pkg;

   localparam logic [1:0] LINK_DISCONNECTED = 2'd0;
   localparam logic [1:0] LINK_CONNECTED    = 2'd1;
   localparam logic [1:0] LINK_SUSPECT      = 2'd2;

   localparam logic [1:0] FAULT_CLEAR  = 2'd0;
   localparam logic [1:0] FAULT_HEADER = 2'd1;
   localparam logic [1:0] FAULT_CRC    = 2'd2;
   localparam logic [1:0] FAULT_LOST   = 2'd3;

   localparam logic [1:0] OUTCOME_SYNC   = 2'd0;
   localparam logic [1:0] OUTCOME_GOOD   = 2'd1;
   localparam logic [1:0] OUTCOME_REJECT = 2'd2;
   localparam logic [1:0] OUTCOME_LOST   = 2'd3;

   localparam logic [7:0] SYNC_BYTE0 = 8'hFF;
   localparam logic [7:0] SYNC_BYTE1 = 8'hAA;
   localparam logic [7:0] SYNC_BYTE2 = 8'h55;
   localparam logic [7:0] SYNC_BYTE3 = 8'hFF;
   localparam logic [7:0] HEADER_SUM = 8'hFF;
   localparam logic [8:0] SYNC_SUM   = 9'h0FF;
   localparam logic [7:0] CRC_POLY   = 8'h07;

   typedef struct packed {
      logic signed [15:0] tx_data;
      logic [7:0]         rx_byte0;
      logic [7:0]         rx_byte1;
      logic [7:0]         rx_byte2;
      logic [7:0]         rx_byte3;
   } req_type;

   typedef struct packed {
      logic [7:0]         tx_byte0;
      logic [7:0]         tx_byte1;
      logic [7:0]         tx_byte2;
      logic [7:0]         tx_byte3;
      logic signed [15:0] rx_value;
      logic [1:0]         outcome;
      logic [1:0]         link_state;
      logic [1:0]         fault_code;
   } rsp_type;

   typedef struct packed {
      logic [1:0] link_status;
      logic [1:0] last_fault;
   } link_type;

   // MSB-first CRC-8, poly 0x07, one byte folded in
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [7:0] crc8_pair(input logic [7:0] hi, input logic [7:0] lo);
      return crc8_feed(crc8_feed(8'h00, hi), lo);
   endfunction

endpackage

`default_nettype wire

>>> sv/fwl_exchange.sv
`default_nettype none

// One exchange: builds the sent bytes, checks the received ones and
// works out the next link state.
module fwl_exchange (
   input  wire fwl_pkg::req_type  req,
   input  wire fwl_pkg::link_type link,
   input  wire logic [7:0]        module_id,
   output fwl_pkg::rsp_type       rsp,
   output fwl_pkg::link_type      link_next
);

   logic [7:0] hi;
   logic [7:0] lo;
   logic [7:0] head_sum;
   logic [8:0] sync_sum;
   logic       head_ok;
   logic       crc_ok;
   logic       framed;

   assign hi       = req.tx_data[15:8];
   assign lo       = req.tx_data[7:0];
   assign head_sum = req.rx_byte0 + module_id;
   assign sync_sum = {1'b0, req.rx_byte1} + {1'b0, req.rx_byte2};
   assign head_ok  = (head_sum == fwl_pkg::HEADER_SUM);
   assign crc_ok   = (fwl_pkg::crc8_pair(req.rx_byte1, req.rx_byte2) == req.rx_byte3);
   assign framed   = (link.link_status == fwl_pkg::LINK_CONNECTED) ||
                     (link.link_status == fwl_pkg::LINK_SUSPECT);

   always_comb begin
      link_next    = link;
      rsp.rx_value = 16'sd0;
      rsp.outcome  = fwl_pkg::OUTCOME_SYNC;
      if (framed) begin
         rsp.tx_byte0 = module_id;
         rsp.tx_byte1 = hi;
         rsp.tx_byte2 = lo;
         rsp.tx_byte3 = fwl_pkg::crc8_pair(hi, lo);
         if (head_ok && crc_ok) begin
            link_next.link_status = fwl_pkg::LINK_CONNECTED;
            link_next.last_fault  = fwl_pkg::FAULT_CLEAR;
            rsp.outcome           = fwl_pkg::OUTCOME_GOOD;
            rsp.rx_value          = {req.rx_byte1, req.rx_byte2};
         end else if (link.link_status == fwl_pkg::LINK_SUSPECT) begin
            link_next.link_status = fwl_pkg::LINK_DISCONNECTED;
            link_next.last_fault  = fwl_pkg::FAULT_LOST;
            rsp.outcome           = fwl_pkg::OUTCOME_LOST;
         end else begin
            link_next.link_status = fwl_pkg::LINK_SUSPECT;
            link_next.last_fault  = head_ok ? fwl_pkg::FAULT_CRC : fwl_pkg::FAULT_HEADER;
            rsp.outcome           = fwl_pkg::OUTCOME_REJECT;
         end
      end else begin
         rsp.tx_byte0 = fwl_pkg::SYNC_BYTE0;
         rsp.tx_byte1 = fwl_pkg::SYNC_BYTE1;
         rsp.tx_byte2 = fwl_pkg::SYNC_BYTE2;
         rsp.tx_byte3 = fwl_pkg::SYNC_BYTE3;
         // fault code is kept as is, even on connect
         link_next.link_status = (sync_sum == fwl_pkg::SYNC_SUM) ?
                                 fwl_pkg::LINK_CONNECTED : fwl_pkg::LINK_DISCONNECTED;
      end
      rsp.link_state = link_next.link_status;
      rsp.fault_code = link_next.last_fault;
   end

endmodule

`default_nettype wire

>>> sv/framed_word_link_endpoint.sv
// Channel  Direction  Ports                               Word
// req      in         req_valid req_ready req_data        send word, four received bytes
// rsp      out        rsp_valid rsp_ready rsp_data        four sent bytes, word, status
// csr      in         csr_valid csr_ready csr_data        module id (always ready)
//
// One exchange per cycle while rsp is not stalled; a word passes through the input
// register, then the result register, before it leaves on rsp.
// Link state and fault code update when a word moves into the result register.
// Synchronous active-high reset: disconnected, fault lost, module id 0.
// A stalled rsp holds the result; req keeps taking one more word into the
// input register while that register is empty.
`default_nettype none
`include "framed_word_link_endpoint_assert.svh"

module framed_word_link_endpoint (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fwl_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output fwl_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [7:0]       csr_data
);

   fwl_pkg::req_type  req_ff;
   logic              req_valid_ff;
   fwl_pkg::rsp_type  rsp_ff;
   fwl_pkg::rsp_type  rsp_in;
   logic              rsp_valid_ff;
   fwl_pkg::link_type link_ff;
   fwl_pkg::link_type link_in;
   logic [7:0]        module_id_ff;
   logic              out_open;
   logic              advance;
   logic              rsp_good;
   logic              rsp_lost;
   logic              rsp_up;
   logic              rsp_down;
   logic              rsp_match;
   logic              rsp_zero;
   logic              in_stall;

   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && out_open;
   assign req_ready = !req_valid_ff || out_open;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   fwl_exchange u_exchange (
      .req       (req_ff),
      .link      (link_ff),
      .module_id (module_id_ff),
      .rsp       (rsp_in),
      .link_next (link_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         link_ff.link_status <= fwl_pkg::LINK_DISCONNECTED;
         link_ff.last_fault  <= fwl_pkg::FAULT_LOST;
         module_id_ff        <= 8'h00;
      end else begin
         if (req_valid && req_ready) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            link_ff      <= link_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            module_id_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_good  = rsp_valid_ff && (rsp_ff.outcome == fwl_pkg::OUTCOME_GOOD);
   assign rsp_lost  = rsp_valid_ff && (rsp_ff.outcome == fwl_pkg::OUTCOME_LOST);
   assign rsp_up    = (rsp_ff.link_state == fwl_pkg::LINK_CONNECTED) &&
                      (rsp_ff.fault_code == fwl_pkg::FAULT_CLEAR);
   assign rsp_down  = (rsp_ff.link_state == fwl_pkg::LINK_DISCONNECTED) &&
                      (rsp_ff.fault_code == fwl_pkg::FAULT_LOST);
   assign rsp_match = (link_ff.link_status == rsp_ff.link_state) &&
                      (link_ff.last_fault == rsp_ff.fault_code);
   assign rsp_zero  = (rsp_ff.rx_value == 16'sd0);
   assign in_stall  = req_valid_ff && !out_open;

   `FWL_ASSERT_NOW(a_state_matches_rsp, clock, reset, rsp_valid_ff, rsp_match)
   `FWL_ASSERT_NOW(a_good_connects, clock, reset, rsp_good, rsp_up)
   `FWL_ASSERT_NOW(a_lost_drops, clock, reset, rsp_lost, rsp_down)
   `FWL_ASSERT_NOW(a_value_only_good, clock, reset, rsp_valid_ff && !rsp_good, rsp_zero)
   `FWL_ASSERT_NEXT(a_input_held, clock, reset, in_stall, req_valid_ff && $stable(req_ff))
   `FWL_ASSERT_NEXT(a_link_held, clock, reset, in_stall, $stable(link_ff))

endmodule

`default_nettype wire
